// File: rtl/text_console_buffer_core_defines.svh
// Assertion macros shared by the checker of the text console buffer.
// Needs nothing else; take it in with a plain include.
`ifndef TEXT_CONSOLE_BUFFER_CORE_DEFINES_SVH
`define TEXT_CONSOLE_BUFFER_CORE_DEFINES_SVH

// Consequent checked at the same edge as the antecedent.
`define TCB_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define TCB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/tcb_pkg.sv
// Shared types and constants of the text console buffer.
// Used by the RAM, the sweep engine, the top level and the checker.
`default_nettype none

package tcb_pkg;

    localparam int DEF_COLUMNS  = 80;
    localparam int DEF_ROWS     = 25;

    localparam int CMD_W        = 3;
    localparam int CHAR_W       = 8;
    localparam int COLOR_W      = 8;
    localparam int COL_PORT_W   = 7;
    localparam int ROW_PORT_W   = 5;
    localparam int LINES_PORT_W = 5;
    localparam int CELL_W       = CHAR_W + COLOR_W;

    localparam logic [CHAR_W-1:0]  SPACE_CODE   = 8'h20;
    localparam logic [CHAR_W-1:0]  NEWLINE_CODE = 8'h0A;
    localparam logic [COLOR_W-1:0] RESET_COLOR  = 8'h07;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUT     = 3'd0,
        CMD_WRITE   = 3'd1,
        CMD_RECOLOR = 3'd2,
        CMD_READ    = 3'd3,
        CMD_CLEAR   = 3'd4,
        CMD_SCROLL  = 3'd5
    } t_cmd;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_INIT_WAIT,
        ST_IDLE,
        ST_RD_WAIT,
        ST_SWEEP,
        ST_DONE
    } t_state;

    // Request from the command sequencer to the sweep engine.
    typedef struct packed {
        logic              start;
        logic [CELL_W-1:0] blank;
    } t_sweep_req;

    // Status and port strobes of the sweep engine.
    typedef struct packed {
        logic busy;
        logic rd_en;
        logic wr_en;
    } t_sweep_sts;

endpackage

`default_nettype wire

// File: rtl/text_console_buffer_core.sv
// Text console buffer: command sequencer, cursor and text color, result register.
// Depends on tcb_pkg, tcb_ram and tcb_sweep.
//
// A COLUMNS x ROWS screen of 16-bit cells (character low, color high) in one
// RAM with a registered read port, plus a cursor. One command word is worked
// on at a time; o_in_stall stays high until its result word is in the output
// register, which holds it while i_out_stall is high. Put without a scroll,
// write cell, an address out of range, a zero scroll and the unused codes go
// straight to the result state; recolor and read color pass through ST_RD_WAIT
// for the registered RAM read. Clear, scroll, and a put or newline that scrolls
// run the sweep engine, which moves or blanks one cell per cycle over the single
// RAM write port. After reset a clearing pass fills the screen with light grey
// spaces while commands stall; text color writes on the configuration port are
// always ready.
`default_nettype none

module text_console_buffer_core
    import tcb_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_in_valid,
    output logic                         o_in_stall,
    input  wire logic [CMD_W-1:0]        i_cmd,
    input  wire logic [CHAR_W-1:0]       i_char_code,
    input  wire logic [COLOR_W-1:0]      i_cell_color,
    input  wire logic [COL_PORT_W-1:0]   i_cell_column,
    input  wire logic [ROW_PORT_W-1:0]   i_cell_row,
    input  wire logic [LINES_PORT_W-1:0] i_scroll_lines,
    output logic                         o_out_valid,
    input  wire logic                    i_out_stall,
    output logic      [COLOR_W-1:0]      o_read_color,
    output logic      [COL_PORT_W-1:0]   o_cursor_column,
    output logic      [ROW_PORT_W-1:0]   o_cursor_row,
    input  wire logic                    i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire logic [COLOR_W-1:0]      i_cfg_data
);

    localparam int CELLS   = COLUMNS * ROWS;
    localparam int ADDR_W  = $clog2(CELLS);
    localparam int COL_W   = $clog2(COLUMNS);
    localparam int ROW_W   = $clog2(ROWS);
    localparam int LINES_W = $clog2(ROWS + 1);

    t_state             r_state, n_state;
    logic [COL_W-1:0]   r_cur_col, n_cur_col;
    logic [ROW_W-1:0]   r_cur_row, n_cur_row;
    logic [COLOR_W-1:0] r_text_color;
    t_cmd               r_cmd;
    logic [COLOR_W-1:0] r_color;
    logic [ADDR_W-1:0]  r_idx;
    logic [COLOR_W-1:0] r_res_color;

    logic                  r_out_valid;
    logic [COLOR_W-1:0]    r_out_color;
    logic [COL_PORT_W-1:0] r_out_col;
    logic [ROW_PORT_W-1:0] r_out_row;

    logic               w_accept;
    logic               w_addr_ok;
    logic [ADDR_W-1:0]  w_cell_idx;
    logic [ADDR_W-1:0]  w_cur_idx;
    logic               w_is_nl;
    logic               w_line_end;
    logic               w_last_row;
    logic               w_put_scroll;
    logic [LINES_W-1:0] w_lines_sat;
    logic               w_lines_zero;
    logic               w_load_out;

    logic               w_top_wr_en;
    logic [ADDR_W-1:0]  w_top_wr_addr;
    logic [CELL_W-1:0]  w_top_wr_data;
    logic               w_top_rd_en;
    logic [ADDR_W-1:0]  w_top_rd_addr;

    t_sweep_req         w_sweep_req;
    logic [LINES_W-1:0] w_sweep_lines;
    t_sweep_sts         w_sweep_sts;
    logic [ADDR_W-1:0]  w_sweep_rd_addr;
    logic [ADDR_W-1:0]  w_sweep_wr_addr;
    logic [CELL_W-1:0]  w_sweep_wr_data;

    logic               w_ram_wr_en;
    logic [ADDR_W-1:0]  w_ram_wr_addr;
    logic [CELL_W-1:0]  w_ram_wr_data;
    logic               w_ram_rd_en;
    logic [ADDR_W-1:0]  w_ram_rd_addr;
    logic [CELL_W-1:0]  w_ram_rd_data;

    // Decode of the incoming word and the cursor
    assign w_accept     = (r_state == ST_IDLE) && i_in_valid;
    assign w_addr_ok    = (32'(i_cell_column) < COLUMNS) && (32'(i_cell_row) < ROWS);
    assign w_cell_idx   = ADDR_W'(32'(i_cell_row) * COLUMNS + 32'(i_cell_column));
    assign w_cur_idx    = ADDR_W'(32'(r_cur_row) * COLUMNS + 32'(r_cur_col));
    assign w_is_nl      = (i_char_code == NEWLINE_CODE);
    assign w_line_end   = w_is_nl || (r_cur_col == COL_W'(COLUMNS - 1));
    assign w_last_row   = (r_cur_row == ROW_W'(ROWS - 1));
    assign w_put_scroll = w_line_end && w_last_row;
    assign w_lines_sat  = (32'(i_scroll_lines) >= ROWS) ? LINES_W'(ROWS)
                                                        : LINES_W'(i_scroll_lines);
    assign w_lines_zero = (i_scroll_lines == '0);

    always_comb begin
        n_cur_col = r_cur_col;
        n_cur_row = r_cur_row;
        if (w_accept && (t_cmd'(i_cmd) == CMD_PUT)) begin
            if (w_line_end) begin
                n_cur_col = '0;
                if (!w_last_row) begin
                    n_cur_row = r_cur_row + ROW_W'(1);
                end
            end else begin
                n_cur_col = r_cur_col + COL_W'(1);
            end
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_INIT: begin
                n_state = ST_INIT_WAIT;
            end
            ST_INIT_WAIT: begin
                if (!w_sweep_sts.busy) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    unique case (t_cmd'(i_cmd))
                        CMD_PUT:     n_state = w_put_scroll ? ST_SWEEP : ST_DONE;
                        CMD_WRITE:   n_state = ST_DONE;
                        CMD_RECOLOR,
                        CMD_READ:    n_state = w_addr_ok ? ST_RD_WAIT : ST_DONE;
                        CMD_CLEAR:   n_state = ST_SWEEP;
                        CMD_SCROLL:  n_state = w_lines_zero ? ST_DONE : ST_SWEEP;
                        default:     n_state = ST_DONE;
                    endcase
                end
            end
            ST_RD_WAIT: begin
                n_state = ST_DONE;
            end
            ST_SWEEP: begin
                if (!w_sweep_sts.busy) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_INIT;
            end
        endcase
    end

    // State outputs: RAM access, sweep request, result load
    always_comb begin
        w_top_wr_en       = 1'b0;
        w_top_wr_addr     = w_cell_idx;
        w_top_wr_data     = {i_cell_color, i_char_code};
        w_top_rd_en       = 1'b0;
        w_top_rd_addr     = w_cell_idx;
        w_sweep_req.start = 1'b0;
        w_sweep_req.blank = {r_text_color, SPACE_CODE};
        w_sweep_lines     = LINES_W'(ROWS);
        w_load_out        = 1'b0;
        unique case (r_state)
            ST_INIT: begin
                w_sweep_req.start = 1'b1;
                w_sweep_req.blank = {RESET_COLOR, SPACE_CODE};
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    unique case (t_cmd'(i_cmd))
                        CMD_PUT: begin
                            w_top_wr_en       = !w_is_nl;
                            w_top_wr_addr     = w_cur_idx;
                            w_top_wr_data     = {r_text_color, i_char_code};
                            w_sweep_req.start = w_put_scroll;
                            w_sweep_lines     = LINES_W'(1);
                        end
                        CMD_WRITE: begin
                            w_top_wr_en = w_addr_ok;
                        end
                        CMD_RECOLOR,
                        CMD_READ: begin
                            w_top_rd_en = w_addr_ok;
                        end
                        CMD_CLEAR: begin
                            w_sweep_req.start = 1'b1;
                        end
                        CMD_SCROLL: begin
                            w_sweep_req.start = !w_lines_zero;
                            w_sweep_lines     = w_lines_sat;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_RD_WAIT: begin
                // write back the character under the new color
                w_top_wr_en   = (r_cmd == CMD_RECOLOR);
                w_top_wr_addr = r_idx;
                w_top_wr_data = {r_color, w_ram_rd_data[CHAR_W-1:0]};
            end
            ST_DONE: begin
                w_load_out = !r_out_valid || !i_out_stall;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_INIT;
            r_cur_col    <= '0;
            r_cur_row    <= '0;
            r_text_color <= RESET_COLOR;
            r_out_valid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cur_col <= n_cur_col;
            r_cur_row <= n_cur_row;
            if (i_cfg_valid) begin
                r_text_color <= i_cfg_data;
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd       <= t_cmd'(i_cmd);
            r_color     <= i_cell_color;
            r_idx       <= w_cell_idx;
            r_res_color <= '0;
        end else if ((r_state == ST_RD_WAIT) && (r_cmd == CMD_READ)) begin
            r_res_color <= w_ram_rd_data[CELL_W-1:CHAR_W];
        end
        if (w_load_out) begin
            r_out_color <= r_res_color;
            r_out_col   <= COL_PORT_W'(r_cur_col);
            r_out_row   <= ROW_PORT_W'(r_cur_row);
        end
    end

    // RAM port arbitration: the sweep owns the RAM while it runs
    assign w_ram_wr_en   = w_sweep_sts.wr_en | w_top_wr_en;
    assign w_ram_wr_addr = w_sweep_sts.wr_en ? w_sweep_wr_addr : w_top_wr_addr;
    assign w_ram_wr_data = w_sweep_sts.wr_en ? w_sweep_wr_data : w_top_wr_data;
    assign w_ram_rd_en   = w_sweep_sts.rd_en | w_top_rd_en;
    assign w_ram_rd_addr = w_sweep_sts.rd_en ? w_sweep_rd_addr : w_top_rd_addr;

    tcb_ram #(
        .WIDTH(CELL_W),
        .DEPTH(CELLS)
    ) u_ram (
        .i_clk    (i_clk),
        .i_wr_en  (w_ram_wr_en),
        .i_wr_addr(w_ram_wr_addr),
        .i_wr_data(w_ram_wr_data),
        .i_rd_en  (w_ram_rd_en),
        .i_rd_addr(w_ram_rd_addr),
        .o_rd_data(w_ram_rd_data)
    );

    tcb_sweep #(
        .COLUMNS(COLUMNS),
        .ROWS   (ROWS)
    ) u_sweep (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (w_sweep_req),
        .i_lines  (w_sweep_lines),
        .i_rd_data(w_ram_rd_data),
        .o_sts    (w_sweep_sts),
        .o_rd_addr(w_sweep_rd_addr),
        .o_wr_addr(w_sweep_wr_addr),
        .o_wr_data(w_sweep_wr_data)
    );

    assign o_in_stall      = (r_state != ST_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_read_color    = r_out_color;
    assign o_cursor_column = r_out_col;
    assign o_cursor_row    = r_out_row;
    assign o_cfg_ready     = 1'b1;

endmodule

`default_nettype wire

// File: rtl/tcb_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on tcb_pkg for default sizes.
`default_nettype none

module tcb_ram
    import tcb_pkg::*;
#(
    parameter int WIDTH = CELL_W,
    parameter int DEPTH = DEF_COLUMNS * DEF_ROWS,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_wr_en,
    input  wire logic [ADDR_W-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]  i_wr_data,
    input  wire logic              i_rd_en,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// File: rtl/tcb_sweep.sv
// Sweep engine: moves rows up by a number of lines and blanks the rows freed,
// one cell a cycle through the cell RAM. Depends on tcb_pkg.
`default_nettype none

module tcb_sweep
    import tcb_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS,
    localparam int CELLS   = COLUMNS * ROWS,
    localparam int ADDR_W  = $clog2(CELLS),
    localparam int LINES_W = $clog2(ROWS + 1)
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_sweep_req         i_req,
    input  wire logic [LINES_W-1:0] i_lines,
    input  wire logic [CELL_W-1:0]  i_rd_data,
    output t_sweep_sts              o_sts,
    output logic      [ADDR_W-1:0]  o_rd_addr,
    output logic      [ADDR_W-1:0]  o_wr_addr,
    output logic      [CELL_W-1:0]  o_wr_data
);

    logic              r_busy;
    logic [ADDR_W-1:0] r_ptr;
    logic [ADDR_W-1:0] r_keep;
    logic [ADDR_W-1:0] r_offset;
    logic [CELL_W-1:0] r_blank;
    logic              r_wv;
    logic [ADDR_W-1:0] r_wa;
    logic              r_wcopy;
    logic              w_copy;

    // Destinations below the kept cell count take a moved cell, the rest a blank.
    assign w_copy = (r_ptr < r_keep);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_wv   <= 1'b0;
        end else begin
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_ptr == ADDR_W'(CELLS - 1))) begin
                r_busy <= 1'b0;
            end
            r_wv <= r_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_ptr    <= '0;
            r_keep   <= ADDR_W'(CELLS - 32'(i_lines) * COLUMNS);
            r_offset <= ADDR_W'(32'(i_lines) * COLUMNS);
            r_blank  <= i_req.blank;
        end else if (r_busy) begin
            r_ptr <= r_ptr + ADDR_W'(1);
        end
        r_wa    <= r_ptr;
        r_wcopy <= w_copy;
    end

    // Source always runs ahead of the destination, so the registered write
    // never lands on a cell still to be read.
    assign o_rd_addr   = r_ptr + r_offset;
    assign o_wr_addr   = r_wa;
    assign o_wr_data   = r_wcopy ? i_rd_data : r_blank;
    assign o_sts.busy  = r_busy | r_wv;
    assign o_sts.rd_en = r_busy & w_copy;
    assign o_sts.wr_en = r_wv;

endmodule

`default_nettype wire

// File: rtl/tcb_checker.sv
// Port-level checker of the text console buffer, bound to the top level.
// Depends on tcb_pkg and text_console_buffer_core_defines.svh.
`default_nettype none

`include "text_console_buffer_core_defines.svh"

module tcb_checker
    import tcb_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
) (
    input wire logic                    i_clk,
    input wire logic                    i_rst_n,
    input wire logic                    i_in_valid,
    input wire logic                    o_in_stall,
    input wire logic                    o_out_valid,
    input wire logic                    i_out_stall,
    input wire logic [COLOR_W-1:0]      o_read_color,
    input wire logic [COL_PORT_W-1:0]   o_cursor_column,
    input wire logic [ROW_PORT_W-1:0]   o_cursor_row
);

    // a stalled result word holds
    `TCB_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_read_color) && $stable(o_cursor_column) && $stable(o_cursor_row), "result word changed under stall")

    // the cursor reported never leaves the screen
    `TCB_ASSERT_SAME(a_cursor_range, i_clk, i_rst_n, o_out_valid, (32'(o_cursor_column) < COLUMNS) && (32'(o_cursor_row) < ROWS), "cursor outside the screen")

    // one command word at a time
    `TCB_ASSERT_NEXT(a_one_word, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall, "second word taken while busy")

    // reset starts the clearing pass with input stalled and no result
    `TCB_ASSERT_NEXT(a_reset_clear, i_clk, 1'b1, !i_rst_n, o_in_stall && !o_out_valid, "input open right after reset")

endmodule

bind text_console_buffer_core tcb_checker #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
) u_tcb_checker (.*);

`default_nettype wire
